@@ rtl/i2cmts_pkg.sv @@
// Shared types and codes for the I2C master transaction sequencer.
`timescale 1ns / 1ps
package i2cmts_pkg;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_BEGIN,
        OP_STATUS
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_START,
        ACT_SEND,
        ACT_ACK,
        ACT_NACK,
        ACT_STOP
    } action_t;

    localparam logic [7:0] ST_MASK         = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    localparam logic [5:0] POS_MAX = 6'd63;

    typedef struct packed {
        logic       rejected;
        logic       busy_now;
        logic [7:0] fail_status;
        logic       failed;
        logic       done_res;
        logic [4:0] rx_position;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic [7:0] tx_byte;
        action_t    action;
    } result_t;

endpackage

@@ rtl/i2cmts_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module i2cmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/i2c_master_transaction_sequencer.sv @@
// Top level of the I2C master transaction sequencer.
// An accepted item is held in the input register; its result item is registered in the output register.
// Throughput: one item per cycle while the result output is not stalled; the store read
// address is taken from the next send position, so each send byte is ready in time.
// Reset: rst_n clears the pipeline valids, busy flag, counters and address byte.
// The byte store is not cleared; entries hold undefined data until loaded.
`timescale 1ns / 1ps
module i2c_master_transaction_sequencer
    import i2cmts_pkg::*;
#(
    parameter int BUF_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // read_not_write, address[6:0], length[4:0], payload_byte[7:0], status[7:0],
    // rx_byte[7:0], zero pad
    input  logic [39:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // action[2:0], tx_byte[7:0], rx_valid, rx_data[7:0], rx_position[4:0],
    // done_res, failed, fail_status[7:0], busy_now, rejected, zero pad
    output logic [39:0] m_tdata
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(BUF_DEPTH - 1);

    logic          in_valid_reg, in_valid_next;
    op_t           in_op_reg;
    logic          in_rnw_reg;
    logic [6:0]    in_addr_reg;
    logic [4:0]    in_len_reg;
    logic [7:0]    in_payload_reg;
    logic [7:0]    in_status_reg;
    logic [7:0]    in_rx_reg;

    logic          busy_reg, busy_next;
    logic [5:0]    pos_reg, pos_next;
    logic [5:0]    total_reg, total_next;
    logic [AW-1:0] load_ptr_reg, load_ptr_next;
    logic [AW-1:0] sidx_reg, sidx_next;
    logic [7:0]    sla_reg, sla_next;

    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, res;

    logic          accept, proc;
    logic          ram_we;
    logic [7:0]    ram_rdata;
    logic [7:0]    st_masked;
    logic [5:0]    pos_m1;

    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign accept   = s_tvalid && s_tready;

    assign in_valid_next  = accept ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
    assign out_valid_next = proc ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign st_masked = in_status_reg & ST_MASK;
    assign pos_m1    = pos_reg - 6'd1;

    i2cmts_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_ptr_reg),
        .wdata (in_payload_reg),
        .raddr (sidx_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        busy_next     = busy_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        load_ptr_next = load_ptr_reg;
        sidx_next     = sidx_reg;
        sla_next      = sla_reg;
        ram_we        = 1'b0;
        res           = '0;
        res.action    = ACT_NONE;

        if (proc)
        begin
            unique case (in_op_reg)
                OP_LOAD:
                begin
                    if (busy_reg)
                    begin
                        res.rejected = 1'b1;
                    end
                    else
                    begin
                        ram_we        = 1'b1;
                        load_ptr_next = (load_ptr_reg == IDX_LAST) ? '0
                                                                   : load_ptr_reg + 1'b1;
                    end
                end
                OP_BEGIN:
                begin
                    if (busy_reg)
                    begin
                        res.rejected = 1'b1;
                    end
                    else
                    begin
                        sla_next      = {in_addr_reg, in_rnw_reg};
                        total_next    = {1'b0, in_len_reg} + 6'd1;
                        pos_next      = '0;
                        load_ptr_next = '0;
                        sidx_next     = IDX_LAST;
                        busy_next     = 1'b1;
                        res.action    = ACT_START;
                    end
                end
                OP_STATUS:
                begin
                    if (busy_reg)
                    begin
                        unique case (st_masked) inside
                            ST_START, ST_REP_START, ST_MT_SLA_ACK, ST_MT_DATA_ACK:
                            begin
                                if (pos_reg < total_reg)
                                begin
                                    res.action  = ACT_SEND;
                                    res.tx_byte = (pos_reg == '0) ? sla_reg : ram_rdata;
                                    if (pos_reg != POS_MAX)
                                    begin
                                        pos_next  = pos_reg + 6'd1;
                                        sidx_next = (sidx_reg == IDX_LAST) ? '0
                                                                           : sidx_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    res.action   = ACT_STOP;
                                    res.done_res = 1'b1;
                                    busy_next    = 1'b0;
                                end
                            end
                            ST_MR_DATA_ACK, ST_MR_DATA_NACK:
                            begin
                                res.rx_valid    = 1'b1;
                                res.rx_data     = in_rx_reg;
                                res.rx_position = (pos_reg == '0) ? '0 : pos_m1[4:0];
                                if (pos_reg != POS_MAX)
                                begin
                                    pos_next  = pos_reg + 6'd1;
                                    sidx_next = (sidx_reg == IDX_LAST) ? '0
                                                                       : sidx_reg + 1'b1;
                                end
                                if (st_masked == ST_MR_DATA_ACK)
                                begin
                                    res.action = ({1'b0, pos_next} + 7'd1 < {1'b0, total_reg})
                                                 ? ACT_ACK : ACT_NACK;
                                end
                                else
                                begin
                                    res.action   = ACT_STOP;
                                    res.done_res = 1'b1;
                                    busy_next    = 1'b0;
                                end
                            end
                            ST_MR_SLA_ACK:
                            begin
                                res.action = ({1'b0, pos_reg} + 7'd1 < {1'b0, total_reg})
                                             ? ACT_ACK : ACT_NACK;
                            end
                            default:
                            begin
                                res.action      = ACT_STOP;
                                res.done_res    = 1'b1;
                                res.failed      = 1'b1;
                                res.fail_status = st_masked;
                                busy_next       = 1'b0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    res.action = ACT_NONE;
                end
            endcase
        end

        res.busy_now = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            total_reg     <= '0;
            load_ptr_reg  <= '0;
            sidx_reg      <= IDX_LAST;
            sla_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            load_ptr_reg  <= load_ptr_next;
            sidx_reg      <= sidx_next;
            sla_reg       <= sla_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg      <= op_t'(s_tuser);
            in_rnw_reg     <= s_tdata[0];
            in_addr_reg    <= s_tdata[7:1];
            in_len_reg     <= s_tdata[12:8];
            in_payload_reg <= s_tdata[20:13];
            in_status_reg  <= s_tdata[28:21];
            in_rx_reg      <= s_tdata[36:29];
        end
        if (proc)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule

@@ rtl/i2cmts_checker.sv @@
// Port-level assertions for the I2C master transaction sequencer, with bind.
`timescale 1ns / 1ps
module i2cmts_checker
    import i2cmts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result item valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[36] |-> m_tdata[2:0] == ACT_NONE && !m_tdata[25] && m_tdata[35])
        else $error("rejected item caused an action or ended a transaction");

    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25] |-> m_tdata[2:0] == ACT_STOP && !m_tdata[35])
        else $error("finished transaction without stop or still busy");

    a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[26] |-> m_tdata[25] && m_tdata[29:27] == 3'b000)
        else $error("failure not reported as finished or status not masked");

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb.sv @@
// Self-checking testbench for the I2C master transaction sequencer.
`timescale 1ns / 1ps
module tb;
    import i2cmts_pkg::*;

    localparam int          BUF_DEPTH    = 32;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_REPORTS  = 40;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [7:0]  ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0]  ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0]  ST_ARB_LOST     = 8'h38;

    typedef struct {
        logic [1:0] op;
        logic       rnw;
        logic [6:0] addr;
        logic [4:0] len;
        logic [7:0] payload;
        logic [7:0] status;
        logic [7:0] rx_byte;
    } bus_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    logic        steady;
    int unsigned mismatches;
    int unsigned productive_items;
    int unsigned n_done;
    int unsigned n_failed;
    int unsigned n_rx;
    int unsigned n_rejected;

    result_t     expected_results[$];

    logic        seq_busy;
    logic [7:0]  payload_store[BUF_DEPTH];
    logic        payload_loaded[BUF_DEPTH];
    logic [5:0]  bus_pos;
    logic [5:0]  bus_total;
    logic [4:0]  load_idx;
    logic [7:0]  addr_byte;

    i2c_master_transaction_sequencer #(
        .BUF_DEPTH(BUF_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(0, 2);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [39:0] pack_cmd(input bus_cmd_t c);
        return {3'b000, c.rx_byte, c.status, c.payload, c.len, c.addr, c.rnw};
    endfunction

    function automatic bus_cmd_t rand_cmd(input logic [1:0] op);
        bus_cmd_t c;
        c.op      = op;
        c.rnw     = 1'($urandom);
        c.addr    = 7'($urandom);
        c.len     = 5'($urandom);
        c.payload = 8'($urandom);
        c.status  = 8'($urandom);
        c.rx_byte = 8'($urandom);
        return c;
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 10))
            0:       return ST_START;
            1:       return ST_REP_START;
            2:       return ST_MT_SLA_ACK;
            3:       return ST_MT_DATA_ACK;
            4:       return ST_MR_SLA_ACK;
            5:       return ST_MR_DATA_ACK;
            6:       return ST_MR_DATA_NACK;
            7:       return ST_MT_SLA_NACK;
            8:       return ST_MT_DATA_NACK;
            9:       return ST_ARB_LOST;
            default: return 8'($urandom);
        endcase
    endfunction

    // wanted length, limited to the longest run of loaded store entries from index zero
    function automatic logic [4:0] safe_len(input logic [4:0] want);
        int n;
        n = 0;
        while (n < BUF_DEPTH && payload_loaded[n])
            n++;
        return (int'(want) <= n) ? want : 5'(n);
    endfunction

    function automatic void bump_pos();
        if (bus_pos < POS_MAX)
            bus_pos = bus_pos + 6'd1;
    endfunction

    function automatic action_t reply_action();
        return (int'(bus_pos) + 1 < int'(bus_total)) ? ACT_ACK : ACT_NACK;
    endfunction

    function automatic void end_transaction(inout result_t r);
        r.action   = ACT_STOP;
        r.done_res = 1'b1;
        seq_busy   = 1'b0;
        n_done++;
    endfunction

    function automatic void deliver_rx(inout result_t r, input logic [7:0] rx);
        logic [5:0] prev;
        prev          = bus_pos - 6'd1;
        r.rx_valid    = 1'b1;
        r.rx_data     = rx;
        r.rx_position = (bus_pos == 6'd0) ? 5'd0 : prev[4:0];
        bump_pos();
        n_rx++;
    endfunction

    function automatic result_t step_sequencer(input bus_cmd_t c);
        result_t    r;
        logic [7:0] s;
        logic [5:0] idx;
        r   = '0;
        s   = c.status & ST_MASK;
        idx = bus_pos - 6'd1;
        case (c.op)
            OP_LOAD:
                if (seq_busy)
                    r.rejected = 1'b1;
                else
                begin
                    payload_store[load_idx]  = c.payload;
                    payload_loaded[load_idx] = 1'b1;
                    load_idx                 = load_idx + 5'd1;
                end
            OP_BEGIN:
                if (seq_busy)
                    r.rejected = 1'b1;
                else
                begin
                    addr_byte = {c.addr, c.rnw};
                    bus_total = {1'b0, c.len} + 6'd1;
                    bus_pos   = 6'd0;
                    load_idx  = 5'd0;
                    seq_busy  = 1'b1;
                    r.action  = ACT_START;
                end
            OP_STATUS:
                if (seq_busy)
                begin
                    case (s)
                        ST_START, ST_REP_START, ST_MT_SLA_ACK, ST_MT_DATA_ACK:
                            if (bus_pos < bus_total)
                            begin
                                r.action  = ACT_SEND;
                                r.tx_byte = (bus_pos == 6'd0) ? addr_byte
                                                              : payload_store[idx[4:0]];
                                bump_pos();
                            end
                            else
                                end_transaction(r);
                        ST_MR_DATA_ACK:
                        begin
                            deliver_rx(r, c.rx_byte);
                            r.action = reply_action();
                        end
                        ST_MR_SLA_ACK:
                            r.action = reply_action();
                        ST_MR_DATA_NACK:
                        begin
                            deliver_rx(r, c.rx_byte);
                            end_transaction(r);
                        end
                        default:
                        begin
                            end_transaction(r);
                            r.failed      = 1'b1;
                            r.fail_status = s;
                            n_failed++;
                        end
                    endcase
                end
            default:
                ;
        endcase
        if (r.rejected)
            n_rejected++;
        r.busy_now = seq_busy;
        return r;
    endfunction

    task automatic send_item(input bus_cmd_t c);
        int unsigned gap;
        result_t     r;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= pack_cmd(c);
        do
            @(posedge clk);
        while (!s_tready);
        r = step_sequencer(c);
        expected_results.push_back(r);
        if (r.action != ACT_NONE || (c.op == OP_LOAD && !r.rejected))
            productive_items++;
    endtask

    task automatic send_load(input logic [7:0] b);
        bus_cmd_t c;
        c         = rand_cmd(OP_LOAD);
        c.payload = b;
        send_item(c);
    endtask

    task automatic send_begin(input logic rnw, input logic [6:0] addr, input logic [4:0] len);
        bus_cmd_t c;
        c      = rand_cmd(OP_BEGIN);
        c.rnw  = rnw;
        c.addr = addr;
        c.len  = len;
        send_item(c);
    endtask

    task automatic send_status(input logic [7:0] code);
        bus_cmd_t c;
        c        = rand_cmd(OP_STATUS);
        c.status = code | 8'($urandom_range(0, 7));
        send_item(c);
    endtask

    task automatic close_open_transaction();
        if (seq_busy)
            send_status(ST_ARB_LOST);
    endtask

    task automatic send_disturbance();
        bus_cmd_t c;
        case ($urandom_range(0, 3))
            0:       c = rand_cmd(OP_LOAD);
            1:       c = rand_cmd(OP_BEGIN);
            2:       c = rand_cmd(OP_UNUSED);
            default:
            begin
                c        = rand_cmd(OP_STATUS);
                c.status = pick_code() | 8'($urandom_range(0, 7));
            end
        endcase
        c.len = safe_len(c.len);
        send_item(c);
    endtask

    task automatic write_transaction();
        int unsigned len;
        int unsigned steps;
        close_open_transaction();
        len = $urandom_range(0, 31);
        repeat (len) send_load(8'($urandom));
        send_begin(1'b0, 7'($urandom), safe_len(5'(len)));
        send_status(ST_START);
        send_status(ST_MT_SLA_ACK);
        steps = 0;
        while (seq_busy && steps < 80)
        begin
            if ($urandom_range(0, 24) == 0)
                send_disturbance();
            else
                send_status(ST_MT_DATA_ACK);
            steps++;
        end
    endtask

    task automatic read_transaction(input logic marathon);
        logic [4:0]  len;
        int unsigned count;
        close_open_transaction();
        len   = safe_len(5'($urandom));
        count = marathon ? $urandom_range(64, 72) : ((len == 0) ? 0 : len - 1);
        send_begin(1'b1, 7'($urandom), len);
        send_status(ST_START);
        send_status(ST_MR_SLA_ACK);
        for (int i = 0; i < count && seq_busy; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_disturbance();
            else
                send_status(ST_MR_DATA_ACK);
        end
        if (seq_busy)
            send_status(ST_MR_DATA_NACK);
    endtask

    task automatic noise_burst();
        bus_cmd_t c;
        repeat ($urandom_range(3, 12))
        begin
            c     = rand_cmd(2'($urandom_range(0, 3)));
            c.len = safe_len(c.len);
            if (c.op == OP_STATUS && $urandom_range(0, 1) == 0)
                c.status = pick_code() | 8'($urandom_range(0, 7));
            send_item(c);
        end
    endtask

    task automatic test_idle_events();
        send_status(ST_START);
        send_item(rand_cmd(OP_UNUSED));
        send_status(ST_MR_DATA_ACK);
    endtask

    task automatic test_directed_write();
        steady = 1'b1;
        send_load(8'h00);
        send_load(8'hFF);
        send_load(8'h5A);
        send_begin(1'b0, 7'h7F, 5'd2);
        send_load(8'h33);
        send_begin(1'b1, 7'h00, 5'd31);
        send_item(rand_cmd(OP_UNUSED));
        send_status(ST_START);
        send_status(ST_MR_SLA_ACK);
        send_status(ST_MT_SLA_ACK);
        send_status(ST_MT_DATA_ACK);
        send_status(ST_MT_DATA_ACK);
        steady = 1'b0;
    endtask

    task automatic test_directed_read();
        send_begin(1'b1, 7'h00, 5'd31);
        send_status(ST_START);
        send_status(ST_MR_SLA_ACK);
        send_status(ST_MR_DATA_ACK);
        send_status(ST_MR_DATA_NACK);
    endtask

    task automatic test_bus_errors();
        send_begin(1'b1, 7'h2A, 5'd0);
        send_status(ST_REP_START);
        send_status(8'hF8);
        send_begin(1'b0, 7'h55, 5'd1);
        send_status(ST_START);
        send_status(ST_MT_SLA_NACK);
    endtask

    task automatic test_random_traffic(input int unsigned target);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = productive_items + target;
        while (productive_items < stop_at)
        begin
            steady = ($urandom_range(0, 5) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 40)
                write_transaction();
            else if (pick < 70)
                read_transaction(1'b0);
            else if (pick < 74)
                read_transaction(1'b1);
            else if (pick < 80)
            begin
                close_open_transaction();
                repeat ($urandom_range(33, 40)) send_load(8'($urandom));
            end
            else
                noise_burst();
        end
        steady = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    initial
    begin : sink_pacing
        int unsigned hold;
        hold     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (steady)
                m_tready <= 1'b1;
            else if (hold != 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 3) != 0)
                m_tready <= 1'b1;
            else
            begin
                hold = pick_gap();
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(result_t)-1:0];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected item, expected none, actual %h",
                             $time, m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("action", 8'(want.action), 8'(got.action));
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
                check_field("rx_data", want.rx_data, got.rx_data);
                check_field("rx_position", 8'(want.rx_position), 8'(got.rx_position));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                check_field("failed", 8'(want.failed), 8'(got.failed));
                check_field("fail_status", want.fail_status, got.fail_status);
                check_field("busy_now", 8'(want.busy_now), 8'(got.busy_now));
                check_field("rejected", 8'(want.rejected), 8'(got.rejected));
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = '0;
        steady           = 1'b0;
        mismatches       = 0;
        productive_items = 0;
        n_done           = 0;
        n_failed         = 0;
        n_rx             = 0;
        n_rejected       = 0;
        seq_busy         = 1'b0;
        bus_pos          = '0;
        bus_total        = '0;
        load_idx         = '0;
        addr_byte        = '0;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            payload_store[i]  = '0;
            payload_loaded[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_events();
        test_directed_write();
        test_directed_read();
        test_bus_errors();
        test_random_traffic(800);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d working items and %0d transactions, %0d of them ending in error,",
                 productive_items, n_done, n_failed);
        $display("with %0d bytes received and %0d loads or begins refused while busy.",
                 n_rx, n_rejected);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
